@@ design/rhc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg: shared widths and constants of the RGB to HSV converter
// Channel and hue widths, numerator widths and pipeline depths.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned ChanW   = 8;   // one colour channel
  localparam int unsigned HueW    = 9;   // hue 0..359
  localparam int unsigned DiffW   = ChanW + 1;   // signed channel difference
  localparam int unsigned HueSumW = 18;  // signed sector offset plus scaled difference
  localparam int unsigned HueNumW = 17;  // magnitude of the hue numerator, up to 300*255
  localparam int unsigned SatNumW = 16;  // 255*delta

  // One quotient bit per divider stage; hue needs nine bits.
  localparam int unsigned DivStages   = 9;
  localparam int unsigned FrontStages = 2;
  localparam int unsigned PipeStages  = FrontStages + DivStages + 1;

  localparam int unsigned Deg60  = 60;
  localparam int unsigned Deg120 = 120;
  localparam int unsigned Deg240 = 240;
  localparam int unsigned Deg360 = 360;

  typedef enum logic [1:0] {
    SectorRed   = 2'd0,
    SectorGreen = 2'd1,
    SectorBlue  = 2'd2
  } sector_e;

endpackage

@@ design/rhc_pipe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pipe_ctrl: valid bits and stage enables
// Per-stage valid flags; a stage loads when it is empty or the next one loads.
// ----------------------------------------------------------------------------
module rhc_pipe_ctrl import rhc_pkg::*; #(
  parameter int unsigned Stages = PipeStages
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              stall_i,
  output logic              stall_o,
  output logic              valid_o,
  output logic [Stages-1:0] en_o
);

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] valid_d;

  // Collapse bubbles: an empty stage always loads.
  always_comb begin
    en_o[Stages-1] = !valid_q[Stages-1] || !stall_i;
    for (int i = Stages - 2; i >= 0; i--) begin
      en_o[i] = !valid_q[i] || en_o[i+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < Stages; i++) begin
      if (en_o[i]) begin
        valid_d[i] = (i == 0) ? valid_i : valid_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !en_o[0];
  assign valid_o = valid_q[Stages-1];

`ifndef SYNTH
  // Back-pressure reaches the input only when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // A beat taken at the input lands in the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> valid_q[0])
    else $error("accepted beat lost at entry");

  // A result held by the receiver stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[Stages-1] && stall_i) |=> valid_q[Stages-1])
    else $error("stalled result dropped");
`endif

endmodule

@@ design/rhc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front: extremes, sector and divider operands
// Stage one finds max, delta and sector; stage two forms the numerators.
// ----------------------------------------------------------------------------
module rhc_front import rhc_pkg::*; (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  logic [ChanW-1:0]    red_i,
  input  logic [ChanW-1:0]    green_i,
  input  logic [ChanW-1:0]    blue_i,
  output logic [HueNumW-1:0]  hue_num_o,
  output logic                hue_neg_o,
  output logic [ChanW-1:0]    delta_o,
  output logic [SatNumW-1:0]  sat_num_o,
  output logic [ChanW-1:0]    hi_o,
  output logic                gray_o
);

  // Stage one
  logic [ChanW-1:0]        hi_d, lo_d, hi_q, delta_q;
  sector_e                 sector_d, sector_q;
  logic signed [DiffW-1:0] diff_d, diff_q;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sector_d = SectorRed;
      hi_d     = red_i;
      diff_d   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sector_d = SectorGreen;
      hi_d     = green_i;
      diff_d   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector_d = SectorBlue;
      hi_d     = blue_i;
      diff_d   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    lo_d = red_i;
    if (green_i < lo_d) lo_d = green_i;
    if (blue_i < lo_d) lo_d = blue_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hi_q     <= hi_d;
      delta_q  <= hi_d - lo_d;
      sector_q <= sector_d;
      diff_q   <= diff_d;
    end
  end

  // Stage two: sector offset plus 60 times the difference, then magnitude
  logic signed [HueSumW-1:0] diff_ext, delta_ext, base, hue_sum;
  logic [HueNumW-1:0]        hue_mag;

  always_comb begin
    diff_ext  = HueSumW'(diff_q);
    delta_ext = $signed(HueSumW'(delta_q));
    case (sector_q)
      SectorRed:   base = '0;
      SectorGreen: base = delta_ext * $signed(HueSumW'(Deg120));
      SectorBlue:  base = delta_ext * $signed(HueSumW'(Deg240));
      default:     base = '0;
    endcase
    hue_sum = base + diff_ext * $signed(HueSumW'(Deg60));
    hue_mag = hue_sum[HueSumW-1] ? HueNumW'(-hue_sum) : HueNumW'(hue_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hue_num_o <= hue_mag;
      hue_neg_o <= hue_sum[HueSumW-1];
      delta_o   <= delta_q;
      sat_num_o <= (SatNumW'(delta_q) << ChanW) - SatNumW'(delta_q);
      hi_o      <= hi_q;
      gray_o    <= (delta_q == '0);
    end
  end

endmodule

@@ design/rhc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div: pipelined restoring divider
// One quotient bit per stage, MSB first; the numerator must stay below
// den << QuoW. Sideband bits travel alongside the operands.
// ----------------------------------------------------------------------------
module rhc_div import rhc_pkg::*; #(
  parameter int unsigned NumW  = HueNumW,
  parameter int unsigned DenW  = ChanW,
  parameter int unsigned QuoW  = DivStages,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic [QuoW-1:0]  en_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [RemW-1:0]  rem_q  [QuoW-1];
  logic [DenW-1:0]  den_q  [QuoW-1];
  logic [QuoW-1:0]  quo_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [RemW-1:0]  rem_in, shifted;
    logic [DenW-1:0]  den_in;
    logic [QuoW-1:0]  quo_in;
    logic [SideW-1:0] side_in;
    logic             fits;

    if (s == 0) begin : g_first
      assign rem_in  = RemW'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign shifted = RemW'(den_in) << (QuoW - 1 - s);
    assign fits    = (rem_in >= shifted);

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        quo_q[s]  <= quo_in | (fits ? (QuoW'(1) << (QuoW - 1 - s)) : '0);
        side_q[s] <= side_in;
      end
    end

    // The last stage keeps only the quotient and the sideband bits.
    if (s < QuoW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s] <= fits ? rem_in - shifted : rem_in;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o  = quo_q[QuoW-1];
  assign side_o = side_q[QuoW-1];

endmodule

@@ design/rgb_to_hsv_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert: 8-bit RGB pixel to hue / saturation / value
// Streaming converter; one pixel in, one HSV triple out, in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: red_i, green_i, blue_i with valid_i; the block drives
//   stall_o. A beat is taken on a rising edge with valid_i high and stall_o
//   low. Output channel: hue_o, saturation_o, brightness_o with valid_o; the
//   receiver drives stall_i, and a beat leaves when valid_o is high and
//   stall_i is low.
//   The pipeline has two front stages (extremes, then numerators), nine
//   divider stages at one quotient bit each, and the output register.
//   Unstalled throughput is one pixel per cycle; divider stages set depth.
//   Under receiver stall the output beat holds and stages behind it keep
//   filling bubbles; stall_o rises only once all twelve stages are full.
//   Reset clears every valid flag, so the pipeline comes up empty; data
//   registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert import rhc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [HueW-1:0]  hue_o,
  output logic [ChanW-1:0] saturation_o,
  output logic [ChanW-1:0] brightness_o
);

  localparam int unsigned OutStage = PipeStages - 1;

  logic [PipeStages-1:0] en;

  // Handshake and stage enables
  rhc_pipe_ctrl #(
    .Stages (PipeStages)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_i (stall_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .en_o    (en)
  );

  // Front end: max, delta, sector, then the two numerators
  logic [HueNumW-1:0] hue_num;
  logic               hue_neg;
  logic [ChanW-1:0]   delta;
  logic [SatNumW-1:0] sat_num;
  logic [ChanW-1:0]   hi;
  logic               gray;

  rhc_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[FrontStages-1:0]),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .hue_num_o (hue_num),
    .hue_neg_o (hue_neg),
    .delta_o   (delta),
    .sat_num_o (sat_num),
    .hi_o      (hi),
    .gray_o    (gray)
  );

  // Hue quotient: |numerator| / delta, carrying sign and brightness along
  logic [DivStages-1:0] hue_quo;
  logic [ChanW:0]       hue_side;

  rhc_div #(
    .NumW  (HueNumW),
    .DenW  (ChanW),
    .QuoW  (DivStages),
    .SideW (ChanW + 1)
  ) u_hue_div (
    .clk_i  (clk_i),
    .en_i   (en[OutStage-1:FrontStages]),
    .num_i  (hue_num),
    .den_i  (delta),
    .side_i ({hue_neg, hi}),
    .quo_o  (hue_quo),
    .side_o (hue_side)
  );

  // Saturation quotient: 255*delta / max, carrying the gray flag
  logic [DivStages-1:0] sat_quo;
  logic                 gray_out;

  rhc_div #(
    .NumW  (SatNumW),
    .DenW  (ChanW),
    .QuoW  (DivStages),
    .SideW (1)
  ) u_sat_div (
    .clk_i  (clk_i),
    .en_i   (en[OutStage-1:FrontStages]),
    .num_i  (sat_num),
    .den_i  (hi),
    .side_i (gray),
    .quo_o  (sat_quo),
    .side_o (gray_out)
  );

  // Output stage: drop the quotients of a gray pixel (zero divisor), and
  // wrap a negative red-sector hue into 300..359.
  logic [HueW-1:0]  hue_d, hue_q;
  logic [ChanW-1:0] sat_d, sat_q, bright_q;

  always_comb begin
    if (gray_out) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      if (hue_side[ChanW] && (hue_quo != '0)) begin
        hue_d = HueW'(Deg360) - HueW'(hue_quo);
      end else begin
        hue_d = HueW'(hue_quo);
      end
      sat_d = sat_quo[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutStage]) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= hue_side[ChanW-1:0];
    end
  end

  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule
